/* design/lru_slot_replacement_top_defines.svh */
// Assertion macros shared by the checker of the LRU slot replacement block.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef LRU_SLOT_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_SLOT_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrs same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrs next-cycle check failed");

`endif

/* design/lrs_pkg.sv */
// Package for the LRU slot replacement block: field widths, defaults and the
// structs passed between the top level and the slot cells. No dependencies.
package lrs_pkg;

	localparam int PART_W = 16;
	localparam int BIN_W = 13;
	localparam int IDX_W = 3;

	localparam int NUM_SLOTS_DEF = 5;
	localparam int PARTS_PER_BIN_DEF = 10;

	// Broadcast from the top level to every cell for the request in flight.
	typedef struct packed {
		logic update;
		logic any_hit;
		logic any_empty;
		logic [BIN_W-1:0] bin;
	} lrs_ctrl_t;

	// Priority chain handed from each cell to its higher-numbered neighbor.
	typedef struct packed {
		logic hit_seen;
		logic empty_seen;
		logic victim_seen;
	} lrs_chain_t;

	// What a cell reports back about the current request.
	typedef struct packed {
		logic target;
		logic [BIN_W-1:0] old_bin;
	} lrs_cell_out_t;

endpackage

/* design/lrs_cell.sv */
// One slot of the LRU store: holds a bin, its valid bit and its recency rank.
// Depends on lrs_pkg for the control, chain and report structs.
module lrs_cell #(
	parameter int NUM_SLOTS = lrs_pkg::NUM_SLOTS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  lrs_pkg::lrs_ctrl_t                         ctrl,
	input  logic [$clog2(NUM_SLOTS)-1:0]               hit_rank,
	input  lrs_pkg::lrs_chain_t                        chain_in,
	output lrs_pkg::lrs_chain_t                        chain_out,
	output logic [$clog2(NUM_SLOTS)-1:0]               rank_tap,
	output lrs_pkg::lrs_cell_out_t                     report
);
	import lrs_pkg::*;

	localparam int RANK_W = $clog2(NUM_SLOTS);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_SLOTS - 1);

	logic [BIN_W-1:0]  bin_q;
	logic              valid_q;
	logic [RANK_W-1:0] rank_q;

	logic take_hit;
	logic take_empty;
	logic take_victim;
	logic target;
	logic ages;

	always_comb begin
		take_hit    = valid_q && (bin_q == ctrl.bin) && !chain_in.hit_seen;
		take_empty  = !valid_q && !chain_in.empty_seen;
		// With every slot full the ranks are a permutation, so only one slot is oldest.
		take_victim = valid_q && (rank_q == RANK_MAX) && !chain_in.victim_seen;

		chain_out.hit_seen    = chain_in.hit_seen || take_hit;
		chain_out.empty_seen  = chain_in.empty_seen || take_empty;
		chain_out.victim_seen = chain_in.victim_seen || take_victim;

		if (ctrl.any_hit) begin
			target = take_hit;
		end else if (ctrl.any_empty) begin
			target = take_empty;
		end else begin
			target = take_victim;
		end

		// On a hit only the slots younger than the hit slot age.
		ages = valid_q && !target && (!ctrl.any_hit || (rank_q < hit_rank));

		rank_tap       = take_hit ? rank_q : '0;
		report.target  = target;
		report.old_bin = (target && !ctrl.any_hit && !ctrl.any_empty) ? bin_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctrl.update) begin
			if (target) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (ages) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.update && target) begin
			bin_q <= ctrl.bin;
		end
	end

endmodule

/* design/lru_slot_replacement_top.sv */
// LRU slot replacement: a request beat is accepted, its bin is computed in the
// first stage, and the slot row is updated as the result moves to the output
// register. Each beat passes through the first-stage register and then the output
// register; one beat per cycle is sustained while the output is not stalled.
// Reset empties every slot at once; no clearing pass is needed.
module lru_slot_replacement_top #(
	parameter int NUM_SLOTS = lrs_pkg::NUM_SLOTS_DEF,
	parameter int PARTS_PER_BIN = lrs_pkg::PARTS_PER_BIN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lrs_pkg::PART_W-1:0] part_number,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lrs_pkg::BIN_W-1:0]  bin_number,
	output logic                       hit,
	output logic [lrs_pkg::IDX_W-1:0]  slot_index,
	output logic                       evicted_valid,
	output logic [lrs_pkg::BIN_W-1:0]  evicted_bin
);
	import lrs_pkg::*;

	localparam int RANK_W = $clog2(NUM_SLOTS);
	// Quotient by reciprocal: exact for 16-bit dividends and divisors up to 256.
	localparam int DIV_SHIFT = 25;
	localparam int RECIP_W = DIV_SHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((2 ** DIV_SHIFT) + PARTS_PER_BIN - 1) / PARTS_PER_BIN);
	localparam int PROD_W = PART_W + RECIP_W;

	logic [PROD_W-1:0] product;
	logic              valid_s1;
	logic [BIN_W-1:0]  bin_s1;
	logic              out_free;
	logic              s1_free;

	lrs_ctrl_t         ctrl;
	lrs_chain_t        chain [NUM_SLOTS+1];
	lrs_cell_out_t     report [NUM_SLOTS];
	logic [RANK_W-1:0] rank_tap [NUM_SLOTS];
	logic [RANK_W-1:0] hit_rank;
	logic [IDX_W-1:0]  idx;
	logic [BIN_W-1:0]  old_bin;

	logic              out_valid_q;
	logic [BIN_W-1:0]  bin_q;
	logic              hit_q;
	logic [IDX_W-1:0]  idx_q;
	logic              evicted_q;
	logic [BIN_W-1:0]  evicted_bin_q;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;
	assign product  = PROD_W'(part_number) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			bin_s1 <= product[DIV_SHIFT +: BIN_W];
		end
	end

	assign chain[0] = '0;

	always_comb begin
		ctrl.update    = valid_s1 && out_free;
		ctrl.any_hit   = chain[NUM_SLOTS].hit_seen;
		ctrl.any_empty = chain[NUM_SLOTS].empty_seen;
		ctrl.bin       = bin_s1;
	end

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		lrs_cell #(
			.NUM_SLOTS(NUM_SLOTS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.hit_rank (hit_rank),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.rank_tap (rank_tap[g]),
			.report   (report[g])
		);
	end

	// Exactly one cell is the target, so the reductions are plain ORs.
	always_comb begin
		hit_rank = '0;
		idx      = '0;
		old_bin  = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit_rank = hit_rank | rank_tap[i];
			old_bin  = old_bin | report[i].old_bin;
			if (report[i].target) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			bin_q         <= bin_s1;
			hit_q         <= ctrl.any_hit;
			idx_q         <= idx;
			evicted_q     <= !ctrl.any_hit && !ctrl.any_empty;
			evicted_bin_q <= old_bin;
		end
	end

	assign out_valid     = out_valid_q;
	assign bin_number    = bin_q;
	assign hit           = hit_q;
	assign slot_index    = idx_q;
	assign evicted_valid = evicted_q;
	assign evicted_bin   = evicted_bin_q;

endmodule

/* design/lrs_checker.sv */
// Port-level checker for the LRU slot replacement block, bound to the top level.
// Depends on lrs_pkg and the assertion macros in lru_slot_replacement_top_defines.svh.
`include "lru_slot_replacement_top_defines.svh"

module lrs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [lrs_pkg::BIN_W-1:0]  bin_number,
	input logic                       hit,
	input logic [lrs_pkg::IDX_W-1:0]  slot_index,
	input logic                       evicted_valid,
	input logic [lrs_pkg::BIN_W-1:0]  evicted_bin
);
	import lrs_pkg::*;

	// A hit never displaces a resident bin.
	`LRS_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted_valid)
	// Without an eviction the reported victim bin is zero.
	`LRS_ASSERT_NOW(a_evict_bin_zero, out_valid && !evicted_valid, evicted_bin == '0)
	// An evicted bin differs from the bin that replaced it.
	`LRS_ASSERT_NOW(a_evict_differs, out_valid && evicted_valid, evicted_bin != bin_number)
	// A stalled result beat holds its slot and bin.
	`LRS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
		out_valid && $stable(bin_number) && $stable(slot_index))

endmodule

bind lru_slot_replacement_top lrs_checker u_lrs_checker (.*);
